/* src/vaer_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the vector rotation core.
// Depends on nothing; used by vaer_sincos, vaer_rot and the top level.
package vaer_pkg;

  localparam int CW = 37;                // internal coordinate width, holds any result before clipping
  localparam int UW = 18;                // Q1.16 unit value width
  localparam int CORDIC_STEPS = 24;
  localparam int SC_LAT = 30;            // angle quantise (4) + pre (1) + steps + post (1)
  localparam int ROT_LAT = 5;            // stages in one Rodrigues unit

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [UW-1:0] unit_t;

  localparam logic OP_AXIS  = 1'b0;
  localparam logic OP_EULER = 1'b1;

  localparam unit_t UNIT_ONE  = 18'sd65536;
  localparam unit_t UNIT_ZERO = 18'sd0;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

/* src/vaer_sincos.sv */
`timescale 1ns / 1ps
// Pipelined sine/cosine: angle quantisation followed by a 24-step CORDIC.
// Depends on vaer_pkg.
module vaer_sincos import vaer_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] angle,
  output unit_t       sin_q,
  output unit_t       cos_q
);

  localparam int AB = ANGLE_BITS;
  localparam int D  = SINE_TABLE_DEPTH;
  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int TW = 2 * IW;
  localparam int PW = AB + IW + 1;
  localparam logic [63:0] TWO32 = 64'd1 << 32;
  localparam logic [63:0] QUO   = TWO32 / D;
  localparam logic [63:0] RMD   = TWO32 % D;
  localparam logic [63:0] MUL   = (64'd1 << 40) / D;
  localparam int XW = 34;
  localparam int ZW = 33;
  localparam logic signed [XW-1:0] GAIN = 34'sd652032874;

  // quantisation: idx = phase*D >> AB, turn = idx*2^32 / D (reciprocal + one correction)
  logic [PW-1:0] ph_prod;
  logic [IW-1:0] idx;
  logic [31:0]   base, base2, turn;
  logic [TW-1:0] t, t2, qd, rem;
  logic [IW-1:0] q0;
  logic [63:0]   rprod;

  assign ph_prod = PW'(AB'(angle)) * PW'(D);
  assign rprod   = 64'(t) * MUL;
  assign qd      = TW'(64'(q0) * 64'(D));
  assign rem     = t2 - qd;

  always_ff @(posedge clk) begin
    if (en) begin
      idx   <= ph_prod[AB +: IW];
      base  <= 32'(64'(idx) * QUO);
      t     <= TW'(64'(idx) * RMD);
      base2 <= base;
      t2    <= t;
      q0    <= rprod[40 +: IW];
      turn  <= (rem >= TW'(D)) ? base2 + 32'(q0) + 32'd1 : base2 + 32'(q0);
    end
  end

  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
  logic                 cf [CORDIC_STEPS+1];
  logic signed [XW-1:0] nx [CORDIC_STEPS];
  logic signed [XW-1:0] ny [CORDIC_STEPS];
  logic signed [ZW-1:0] nz [CORDIC_STEPS];
  logic [31:0] turn_sum, turn_fold;
  logic        fold;

  // fold quadrants 1 and 2 onto 3 and 0, negating the result later
  assign turn_sum  = turn + 32'h40000000;
  assign fold      = turn_sum[31];
  assign turn_fold = fold ? turn - 32'h80000000 : turn;

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!cz[i][ZW-1]) begin
        nx[i] = cx[i] - (cy[i] >>> i);
        ny[i] = cy[i] + (cx[i] >>> i);
        nz[i] = cz[i] - $signed({1'b0, ATAN_TURNS[i]});
      end else begin
        nx[i] = cx[i] + (cy[i] >>> i);
        ny[i] = cy[i] - (cx[i] >>> i);
        nz[i] = cz[i] + $signed({1'b0, ATAN_TURNS[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= GAIN;
      cy[0] <= '0;
      cz[0] <= ZW'($signed(turn_fold));
      cf[0] <= fold;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cx[i+1] <= nx[i];
        cy[i+1] <= ny[i];
        cz[i+1] <= nz[i];
        cf[i+1] <= cf[i];
      end
    end
  end

  // Q2.30 -> Q1.16 round half up, clamp to +-1.0
  function automatic unit_t to_unit(input logic signed [XW-1:0] v, input logic neg);
    logic signed [XW-1:0] r;
    logic signed [19:0]   q;
    unit_t                u;
    r = v + XW'(8192);
    q = r[XW-1:14];
    if (q > 20'sd65536) u = UNIT_ONE;
    else if (q < -20'sd65536) u = -UNIT_ONE;
    else u = q[UW-1:0];
    return neg ? -u : u;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= to_unit(cx[CORDIC_STEPS], cf[CORDIC_STEPS]);
      sin_q <= to_unit(cy[CORDIC_STEPS], cf[CORDIC_STEPS]);
    end
  end

endmodule

/* src/vaer_rot.sv */
`timescale 1ns / 1ps
// One Rodrigues rotation p*c + (k x p)*s + k*(k.p)*(1-c), five register stages.
// Depends on vaer_pkg.
module vaer_rot import vaer_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  coord_t p [3],
  input  unit_t  k [3],
  input  unit_t  s,
  input  unit_t  c,
  output coord_t r [3]
);

  localparam int PW = CW + UW;       // k*p
  localparam int RW = PW + 1 - 16;   // rounded cross product
  localparam int DW = PW + 2 - 16;   // rounded dot product
  localparam int MW = DW + UW + 1;   // d*(1-c)
  localparam int EW = MW - 16;       // dm
  localparam int SW = RW + UW + 2;   // final sum

  // stage 1
  logic signed [PW-1:0] xp [3], xm [3], dp [3];
  coord_t p1 [3];
  unit_t  k1 [3];
  unit_t  s1, c1;
  // stage 2
  logic signed [RW-1:0] cr [3];
  logic signed [DW-1:0] d;
  coord_t p2 [3];
  unit_t  k2 [3];
  unit_t  s2, c2;
  // stage 3
  logic signed [PW-1:0]   pc3 [3];
  logic signed [RW+UW-1:0] cs3 [3];
  logic signed [MW-1:0]   dmp;
  unit_t  k3 [3];
  // stage 4
  logic signed [EW+UW-1:0] kd4 [3];
  logic signed [PW-1:0]    pc4 [3];
  logic signed [RW+UW-1:0] cs4 [3];

  logic signed [PW:0]   xdiff [3];
  logic signed [PW+1:0] dsum;
  logic signed [DW-1:0] dr;
  logic signed [UW:0]   omc;
  logic signed [MW-1:0] dmr;
  logic signed [SW-1:0] tot [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xdiff[i] = (PW+1)'(xp[i]) - (PW+1)'(xm[i]) + (PW+1)'(32768);
      tot[i]   = SW'(pc4[i]) + SW'(cs4[i]) + SW'(kd4[i]) + SW'(32768);
    end
    dsum = (PW+2)'(dp[0]) + (PW+2)'(dp[1]) + (PW+2)'(dp[2]) + (PW+2)'(32768);
    dr   = dsum[PW+1:16];
    omc  = (UW+1)'(65536) - (UW+1)'(c2);
    dmr  = dmp + MW'(32768);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp[0] <= k[1] * p[2];  xm[0] <= k[2] * p[1];
      xp[1] <= k[2] * p[0];  xm[1] <= k[0] * p[2];
      xp[2] <= k[0] * p[1];  xm[2] <= k[1] * p[0];
      for (int i = 0; i < 3; i++) begin
        dp[i] <= k[i] * p[i];
        p1[i] <= p[i];
        k1[i] <= k[i];
        cr[i] <= xdiff[i][PW:16];
        p2[i] <= p1[i];
        k2[i] <= k1[i];
        pc3[i] <= p2[i] * c2;
        cs3[i] <= cr[i] * s2;
        k3[i]  <= k2[i];
        kd4[i] <= k3[i] * $signed(dmr[MW-1:16]);
        pc4[i] <= pc3[i];
        cs4[i] <= cs3[i];
        r[i]   <= tot[i][16 +: CW];
      end
      s1  <= s;
      c1  <= c;
      d   <= dr;
      s2  <= s1;
      c2  <= c1;
      dmp <= d * omc;
    end
  end

endmodule

/* src/vector_axis_euler_rotation_core.sv */
`timescale 1ns / 1ps
// Top level of the vector rotation core: axis (Rodrigues) or X-Y-Z Euler rotation.
// Depends on vaer_pkg, vaer_sincos and vaer_rot.
//
// Rotates one Q16.16 vector per transaction. tuser = 0 rotates about the Q1.16 axis in tdata
// by angle_x; tuser = 1 rotates about X by angle_x, then Y by angle_y, then Z by angle_z.
// Angles are fractions of a turn, quantised to SINE_TABLE_DEPTH steps. Results saturate to
// 32 bits, with m_axis_tuser set when any coordinate was clipped. The core is a 46-stage
// pipeline: 30 stages for the three parallel sine/cosine units (angle quantisation and a
// 24-step CORDIC), 5 for each of three chained Rodrigues units, 1 for saturation and the
// output register. One transaction is accepted every clock unless the output stalls. The whole
// pipeline advances together: it holds while a result sits unread in the output register
// (s_axis_tready = !m_axis_tvalid || m_axis_tready, held low during reset). For the axis
// rotation the second and third units run with a zero angle, which passes the vector through
// unchanged.
module vector_axis_euler_rotation_core import vaer_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x[31:0] vec_y[63:32] vec_z[95:64] axis_x[113:96] axis_y[131:114]
  // axis_z[149:132] angle_x[165:150] angle_y[181:166] angle_z[197:182], zero fill
  input  logic [199:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // out_x[31:0] out_y[63:32] out_z[95:64]
  output logic         m_axis_tuser    // saturated
);

  localparam int LAT = SC_LAT + 3 * ROT_LAT + 1;

  typedef struct packed {
    coord_t px, py, pz;
    unit_t  kx, ky, kz;
  } pay_t;

  logic en;
  logic [LAT-1:0] vld;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign m_axis_tvalid = vld[LAT-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // input unpacking
  logic        op;
  logic [15:0] ang_a, ang_b, ang_c;
  pay_t        pin;

  assign op    = s_axis_tuser;
  assign ang_a = s_axis_tdata[165:150];
  assign ang_b = (op == OP_EULER) ? s_axis_tdata[181:166] : '0;
  assign ang_c = (op == OP_EULER) ? s_axis_tdata[197:182] : '0;

  always_comb begin
    pin.px = CW'($signed(s_axis_tdata[31:0]));
    pin.py = CW'($signed(s_axis_tdata[63:32]));
    pin.pz = CW'($signed(s_axis_tdata[95:64]));
    if (op == OP_EULER) begin
      pin.kx = UNIT_ONE;
      pin.ky = UNIT_ZERO;
      pin.kz = UNIT_ZERO;
    end else begin
      pin.kx = $signed(s_axis_tdata[113:96]);
      pin.ky = $signed(s_axis_tdata[131:114]);
      pin.kz = $signed(s_axis_tdata[149:132]);
    end
  end

  // sine/cosine for all three rotations in parallel
  unit_t sa, ca, sb, cb, sc, cc;

  vaer_sincos #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sc_a (
    .clk(clk), .en(en), .angle(ang_a), .sin_q(sa), .cos_q(ca));
  vaer_sincos #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sc_b (
    .clk(clk), .en(en), .angle(ang_b), .sin_q(sb), .cos_q(cb));
  vaer_sincos #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sc_c (
    .clk(clk), .en(en), .angle(ang_c), .sin_q(sc), .cos_q(cc));

  // vector and axis wait for the sine/cosine units; later angles wait for earlier rotations
  pay_t  pd  [SC_LAT];
  unit_t sbd [ROT_LAT];
  unit_t cbd [ROT_LAT];
  unit_t scd [2*ROT_LAT];
  unit_t ccd [2*ROT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      pd[0]  <= pin;
      sbd[0] <= sb;
      cbd[0] <= cb;
      scd[0] <= sc;
      ccd[0] <= cc;
      for (int i = 1; i < SC_LAT; i++) pd[i] <= pd[i-1];
      for (int i = 1; i < ROT_LAT; i++) begin
        sbd[i] <= sbd[i-1];
        cbd[i] <= cbd[i-1];
      end
      for (int i = 1; i < 2*ROT_LAT; i++) begin
        scd[i] <= scd[i-1];
        ccd[i] <= ccd[i-1];
      end
    end
  end

  coord_t pa [3], ra [3], rb [3], rc [3];
  unit_t  ka [3], kb [3], kc [3];

  assign pa[0] = pd[SC_LAT-1].px;
  assign pa[1] = pd[SC_LAT-1].py;
  assign pa[2] = pd[SC_LAT-1].pz;
  assign ka[0] = pd[SC_LAT-1].kx;
  assign ka[1] = pd[SC_LAT-1].ky;
  assign ka[2] = pd[SC_LAT-1].kz;
  assign kb    = '{UNIT_ZERO, UNIT_ONE, UNIT_ZERO};
  assign kc    = '{UNIT_ZERO, UNIT_ZERO, UNIT_ONE};

  vaer_rot u_rot_a (.clk(clk), .en(en), .p(pa), .k(ka), .s(sa), .c(ca), .r(ra));
  vaer_rot u_rot_b (.clk(clk), .en(en), .p(ra), .k(kb),
                    .s(sbd[ROT_LAT-1]), .c(cbd[ROT_LAT-1]), .r(rb));
  vaer_rot u_rot_c (.clk(clk), .en(en), .p(rb), .k(kc),
                    .s(scd[2*ROT_LAT-1]), .c(ccd[2*ROT_LAT-1]), .r(rc));

  // saturation and output register
  localparam coord_t CMAX = CW'(64'sd2147483647);
  localparam coord_t CMIN = CW'(-64'sd2147483648);

  logic [31:0] oq [3];
  logic [2:0]  clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (rc[i] > CMAX) begin
        oq[i] = CMAX[31:0];
        clip[i] = 1'b1;
      end else if (rc[i] < CMIN) begin
        oq[i] = CMIN[31:0];
        clip[i] = 1'b1;
      end else begin
        oq[i] = rc[i][31:0];
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {oq[2], oq[1], oq[0]};
      m_axis_tuser <= |clip;
    end
  end

endmodule

/* src/vaer_chk.sv */
`timescale 1ns / 1ps
// Port-level checks for the rotation core, bound to the top level.
// Depends on vector_axis_euler_rotation_core.
module vaer_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic         m_axis_tuser
);

  logic sat_ok;
  assign sat_ok = (m_axis_tdata[31:0] == 32'h7FFFFFFF) || (m_axis_tdata[31:0] == 32'h80000000)
               || (m_axis_tdata[63:32] == 32'h7FFFFFFF) || (m_axis_tdata[63:32] == 32'h80000000)
               || (m_axis_tdata[95:64] == 32'h7FFFFFFF) || (m_axis_tdata[95:64] == 32'h80000000);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> sat_ok)
    else $error("saturation flag without a clipped coordinate");

endmodule

bind vector_axis_euler_rotation_core vaer_chk u_vaer_chk (
  .clk(clk), .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
